>>> rtl/skcht_pkg.sv
// Shared types and codes for the string key counting hash table.
package skcht_pkg;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_DROPPED     = 3'd2,
        ST_LOOKUP_HIT  = 3'd3,
        ST_LOOKUP_MISS = 3'd4
    } t_status;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic       operation;
        logic [7:0] character;
        logic       last_char;
        logic       new_chunk;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_index;
        logic [31:0] doc_count;
        logic [31:0] total_count;
    } t_out_word;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

>>> rtl/skcht_stream_if.sv
// Valid/ready stream channel carrying one word per handshake.
interface skcht_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/skcht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module skcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/string_key_counting_hash_table.sv
// From the last character of a word to its result: the hash is reduced modulo SLOTS, then each
//   slot passed over is read, checked and stepped past, comparing characters where lengths match;
//   the deciding slot is read and checked, its characters compared or stored, then the result is posted.
// Throughput: one character word per cycle while a string is collected; one string at a time
//   in the probe engine, bounded by the single read port of the slot RAMs.
// Reset: synchronous, active low; afterwards a clearing pass over every slot zeroes the
//   slot metadata RAM while input is held off.
module string_key_counting_hash_table #(
    parameter int SLOTS    = 1024,
    parameter int WORD_LEN = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    skcht_stream_if.sink   i_in,
    skcht_stream_if.source o_out
);
    import skcht_pkg::*;

    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW   = $clog2(WORD_LEN);
    localparam int KEEP = WORD_LEN - 1;
    localparam int MW   = 1 + LW + 64;          // valid, length, doc count, total count
    localparam int CAW  = SW + LW;               // character RAM address: {slot, position}
    // floor(2^32 / SLOTS); the estimated quotient is at most one short
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

    // One-hot control states
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,   // zeroing the metadata RAM after reset
        S_IDLE  = 9'b000000010,   // collecting characters
        S_MOD   = 9'b000000100,   // hash modulo SLOTS
        S_RD    = 9'b000001000,   // metadata read issued
        S_CHK   = 9'b000010000,   // metadata back: empty, length check
        S_CMP   = 9'b000100000,   // character by character compare
        S_WRCHR = 9'b001000000,   // storing the key of a new entry
        S_POST  = 9'b010000000,   // handing result to output register
        S_NEXT  = 9'b100000000    // step to the following slot
    } t_state;

    t_state r_state, n_state;

    // Pending string
    logic [7:0]    r_pend [KEEP];
    logic [LW-1:0] r_plen;
    logic [31:0]   r_hash;
    logic          r_op;
    logic          r_nc;

    // Modulo unit: reciprocal multiply, back-multiply and subtract, one correcting subtract
    logic [31:0]   r_div;
    logic [1:0]    r_bitc;
    logic [63:0]   r_prod;
    logic [31:0]   r_rem;
    logic [31:0]   w_hnz;

    // Probe
    logic [SW-1:0] r_slot;
    logic [SW:0]   r_tries;
    logic [LW-1:0] r_ci;
    logic [31:0]   r_doc;
    logic [31:0]   r_tot;
    logic [SW-1:0] r_clr;

    // Result and output register
    t_out_word     r_res;
    t_out_word     r_obuf;
    logic          r_oval;

    // RAM ports
    logic          w_m_we;
    logic [SW-1:0] w_m_waddr;
    logic [MW-1:0] w_m_wdata;
    logic [MW-1:0] w_m_q;
    logic          w_c_we;
    logic [CAW-1:0] w_c_waddr;
    logic [CAW-1:0] w_c_raddr;
    logic [7:0]    w_c_q;

    // Metadata fields as read
    logic          w_q_valid;
    logic [LW-1:0] w_q_len;
    logic [31:0]   w_q_doc;
    logic [31:0]   w_q_tot;
    logic [31:0]   w_inc_tot;
    logic [31:0]   w_inc_doc;
    logic          w_accept;
    logic          w_last_try;
    logic [SW-1:0] w_slot_inc;

    assign w_q_valid = w_m_q[MW-1];
    assign w_q_len   = w_m_q[64 +: LW];
    assign w_q_doc   = w_m_q[63:32];
    assign w_q_tot   = w_m_q[31:0];

    // saturating increments of the held counts
    assign w_inc_tot = (r_tot == COUNT_MAX) ? r_tot : r_tot + 32'd1;
    assign w_inc_doc = (r_nc && r_doc != COUNT_MAX) ? r_doc + 32'd1 : r_doc;

    // a zero hash counts as 1
    assign w_hnz = (r_div == '0) ? 32'd1 : r_div;

    assign w_last_try = (r_tries == (SW+1)'(SLOTS - 1));
    assign w_slot_inc = (r_slot == SW'(SLOTS - 1)) ? '0 : r_slot + SW'(1);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign o_out.valid = r_oval;
    assign o_out.data  = r_obuf;

    skcht_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_m_we),
        .i_waddr (w_m_waddr),
        .i_wdata (w_m_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_m_q)
    );

    skcht_ram #(.WIDTH(8), .DEPTH(SLOTS * (2 ** LW))) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (r_pend[r_ci]),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_q)
    );

    assign w_c_we    = (r_state == S_WRCHR);
    assign w_c_waddr = {r_slot, r_ci};

    // Character read address: first position from the check, then one ahead of the compare
    always_comb begin
        if (r_state == S_CMP) begin
            w_c_raddr = {r_slot, r_ci + LW'(1)};
        end else begin
            w_c_raddr = {r_slot, {LW{1'b0}}};
        end
    end

    // Metadata write: clearing pass, insert, or count update on an add hit
    always_comb begin
        w_m_we    = 1'b0;
        w_m_waddr = r_slot;
        w_m_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_m_we    = 1'b1;
                w_m_waddr = r_clr;
            end
            S_CHK: begin
                if (r_op == OP_ADD) begin
                    if (!w_q_valid) begin
                        w_m_we    = 1'b1;
                        w_m_wdata = {1'b1, r_plen, 32'd1, 32'd1};
                    end else if (w_q_len == r_plen && r_plen == '0) begin
                        // empty key matches at once
                        w_m_we    = 1'b1;
                        w_m_wdata = {1'b1, r_plen,
                                     (r_nc && w_q_doc != COUNT_MAX) ? w_q_doc + 32'd1 : w_q_doc,
                                     (w_q_tot == COUNT_MAX) ? w_q_tot : w_q_tot + 32'd1};
                    end
                end
            end
            S_CMP: begin
                if (r_op == OP_ADD && w_c_q == r_pend[r_ci] && r_ci == r_plen - LW'(1)) begin
                    w_m_we    = 1'b1;
                    w_m_wdata = {1'b1, r_plen, w_inc_doc, w_inc_tot};
                end
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == SW'(SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept && i_in.data.last_char) n_state = S_MOD;
            S_MOD:   if (r_bitc == 2'd2) n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK: begin
                if (!w_q_valid) begin
                    n_state = (r_op == OP_ADD && r_plen != '0) ? S_WRCHR : S_POST;
                end else if (w_q_len == r_plen) begin
                    n_state = (r_plen == '0) ? S_POST : S_CMP;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_CMP: begin
                if (w_c_q != r_pend[r_ci]) n_state = S_NEXT;
                else if (r_ci == r_plen - LW'(1)) n_state = S_POST;
            end
            S_WRCHR: if (r_ci == r_plen - LW'(1)) n_state = S_POST;
            S_NEXT:  n_state = w_last_try ? S_POST : S_RD;
            S_POST:  if (!r_oval || o_out.ready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_plen  <= '0;
            r_hash  <= HASH_SEED;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register: loaded from the result, else emptied once taken
            if (r_state == S_POST && (!r_oval || o_out.ready)) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + SW'(1);
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_plen < LW'(KEEP)) begin
                            r_pend[r_plen] <= i_in.data.character;
                            r_plen <= r_plen + LW'(1);
                            r_hash <= (r_hash << 5) + r_hash + 32'(i_in.data.character);
                        end
                        if (i_in.data.last_char) begin
                            r_op   <= i_in.data.operation;
                            r_nc   <= i_in.data.new_chunk;
                            r_bitc <= '0;
                            r_div  <= (r_plen < LW'(KEEP))
                                      ? (r_hash << 5) + r_hash + 32'(i_in.data.character)
                                      : r_hash;
                        end
                    end
                end
                S_MOD: begin
                    // steps in order: quotient estimate, remainder below 2*SLOTS,
                    // final correction into the start slot
                    r_bitc  <= r_bitc + 2'd1;
                    r_tries <= '0;
                    r_prod  <= {32'd0, w_hnz} * {32'd0, RECIP};
                    r_rem   <= w_hnz - r_prod[63:32] * 32'(SLOTS);
                    if (r_bitc == 2'd2) begin
                        r_slot <= SW'((r_rem >= 32'(SLOTS)) ? r_rem - 32'(SLOTS) : r_rem);
                    end
                end
                S_CHK: begin
                    r_ci  <= '0;
                    r_doc <= w_q_doc;
                    r_tot <= w_q_tot;
                    if (!w_q_valid) begin
                        if (r_op == OP_ADD) begin
                            r_res <= '{ST_INSERTED, 10'(r_slot), 32'd1, 32'd1};
                        end else begin
                            r_res <= '{ST_LOOKUP_MISS, 10'd0, 32'd0, 32'd0};
                        end
                    end else if (w_q_len == r_plen && r_plen == '0) begin
                        if (r_op == OP_ADD) begin
                            r_res <= '{ST_INCREMENTED, 10'(r_slot),
                                       (r_nc && w_q_doc != COUNT_MAX) ? w_q_doc + 32'd1 : w_q_doc,
                                       (w_q_tot == COUNT_MAX) ? w_q_tot : w_q_tot + 32'd1};
                        end else begin
                            r_res <= '{ST_LOOKUP_HIT, 10'(r_slot), w_q_doc, w_q_tot};
                        end
                    end
                end
                S_CMP: begin
                    r_ci <= r_ci + LW'(1);
                    if (r_op == OP_ADD) begin
                        r_res <= '{ST_INCREMENTED, 10'(r_slot), w_inc_doc, w_inc_tot};
                    end else begin
                        r_res <= '{ST_LOOKUP_HIT, 10'(r_slot), r_doc, r_tot};
                    end
                end
                S_WRCHR: r_ci <= r_ci + LW'(1);
                S_NEXT: begin
                    r_tries <= r_tries + (SW+1)'(1);
                    r_slot  <= w_slot_inc;
                    if (r_op == OP_ADD) begin
                        r_res <= '{ST_DROPPED, 10'd0, 32'd0, 32'd0};
                    end else begin
                        r_res <= '{ST_LOOKUP_MISS, 10'd0, 32'd0, 32'd0};
                    end
                end
                S_POST: begin
                    if (!r_oval || o_out.ready) begin
                        r_obuf <= r_res;
                        r_plen <= '0;
                        r_hash <= HASH_SEED;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
